### src/ppurp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppurp_pkg: shared types and constants of the PPU CPU register port
// Holds the command codes, register addresses, reset values, the controller
// state type and the command bundle from the controller to the datapath.
// ----------------------------------------------------------------------------
package ppurp_pkg;

	// Transaction command codes.
	localparam logic [1:0] CMD_WRITE = 2'd0;
	localparam logic [1:0] CMD_READ  = 2'd1;
	localparam logic [1:0] CMD_EVENT = 2'd2;

	// CPU bus register addresses.
	localparam logic [15:0] REG_CTRL     = 16'h2000;
	localparam logic [15:0] REG_MASK     = 16'h2001;
	localparam logic [15:0] REG_STATUS   = 16'h2002;
	localparam logic [15:0] REG_OAM_ADDR = 16'h2003;
	localparam logic [15:0] REG_OAM_DATA = 16'h2004;
	localparam logic [15:0] REG_SCROLL   = 16'h2005;
	localparam logic [15:0] REG_ADDR     = 16'h2006;
	localparam logic [15:0] REG_DATA     = 16'h2007;
	localparam logic [15:0] REG_OAM_DMA  = 16'h4014;

	// Memory geometry.
	localparam int PAT_DEPTH  = 8192;
	localparam int NAME_DEPTH = 2048;
	localparam int OAM_DEPTH  = 256;
	localparam int BYTE_W     = 8;

	// Last video address (after the 14-bit fold) that maps to a nametable.
	localparam logic [13:0] NAME_LAST = 14'h3EFF;

	// Reset values.
	localparam logic [15:0] SPRITE_ADDR_RST = 16'h0300;
	localparam logic [5:0]  CTRL_RST        = 6'h01;
	localparam logic [4:0]  MASK_RST        = 5'h18;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_DONE
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic capture;
		logic exec;
	} dp_cmd_t;

endpackage

### src/ppurp_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppurp_ram: generic single-port-write, registered-read RAM
// One write port and one read port; read data is registered and appears in
// the cycle after the address is presented.
// ----------------------------------------------------------------------------
module ppurp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256,
	parameter int ADDR_W = $clog2(DEPTH)
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

### src/ppurp_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppurp_ctrl: transaction controller
// Sequences each transaction through capture, execute and result strobe.
// ----------------------------------------------------------------------------
module ppurp_ctrl
	import ppurp_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    start,
	output logic    busy,
	output logic    done,
	output dp_cmd_t dp_cmd
);

	state_t state_q;
	state_t state_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_n;
		end
	end

	always_comb begin
		state_n = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (start) state_n = ST_EXEC;
			end
			ST_EXEC: begin
				state_n = ST_DONE;
			end
			ST_DONE: begin
				state_n = start ? ST_EXEC : ST_IDLE;
			end
			default: begin
				state_n = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		busy           = 1'b0;
		done           = 1'b0;
		dp_cmd.capture = 1'b0;
		dp_cmd.exec    = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				dp_cmd.capture = start;
			end
			ST_EXEC: begin
				busy        = 1'b1;
				dp_cmd.exec = 1'b1;
			end
			ST_DONE: begin
				done           = 1'b1;
				dp_cmd.capture = start;
			end
			default: begin
				busy = 1'b0;
			end
		endcase
	end

endmodule

### src/ppurp_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppurp_dp: register file, video memories and access decode
// Holds the latch and flag registers, the pattern, nametable and sprite
// attribute memories, and computes each transaction's effect.
// ----------------------------------------------------------------------------
module ppurp_dp
	import ppurp_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  dp_cmd_t     dp_cmd,
	input  logic [1:0]  cmd,
	input  logic [15:0] reg_addr,
	input  logic [7:0]  write_data,
	input  logic        vblank_set,
	input  logic        sprite_zero_set,
	output logic [7:0]  read_data,
	output logic        access_error,
	output logic [15:0] nametable_scroll_addr,
	output logic [2:0]  fine_x,
	output logic [15:0] vram_addr_out,
	output logic [15:0] oam_addr_out,
	output logic        nmi_enable,
	output logic        tall_sprites,
	output logic        sprite_table_sel,
	output logic        background_table_sel,
	output logic        background_on,
	output logic        sprites_on
);

	localparam int PAT_AW  = $clog2(PAT_DEPTH);
	localparam int NAME_AW = $clog2(NAME_DEPTH);
	localparam int OAM_AW  = $clog2(OAM_DEPTH);

	// Captured transaction.
	logic [1:0]  cmd_q;
	logic [15:0] addr_q;
	logic [7:0]  wdata_q;
	logic        vb_in_q;
	logic        sz_in_q;

	// Architectural registers.
	logic [15:0] scroll_q, scroll_n;
	logic [2:0]  fine_q, fine_n;
	logic [15:0] va_q, va_n;
	logic [15:0] sa_q, sa_n;
	logic        toggle_q, toggle_n;
	logic        vblank_q, vblank_n;
	logic        sz_q, sz_n;
	logic [5:0]  ctrl_q, ctrl_n;
	logic [4:0]  mask_q, mask_n;

	logic [7:0]  rd_q, rd_n;
	logic        err_q, err_n;

	// Memory ports.
	logic [13:0]        vaddr;
	logic               is_pat, is_name;
	logic [NAME_AW-1:0] name_idx;
	logic               pat_we, name_we, oam_we;
	logic [7:0]         pat_rdata, name_rdata, oam_rdata;

	assign vaddr    = va_q[13:0];
	assign is_pat   = !vaddr[13];
	assign is_name  = vaddr[13] && (vaddr <= NAME_LAST);
	// Two tables: bit 11 picks the table, mirrored every 4 KiB.
	assign name_idx = {vaddr[11], vaddr[NAME_AW-2:0]};

	ppurp_ram #(.WIDTH(BYTE_W), .DEPTH(PAT_DEPTH)) u_pat_ram (
		.clk   (clk),
		.we    (pat_we),
		.waddr (vaddr[PAT_AW-1:0]),
		.wdata (wdata_q),
		.raddr (vaddr[PAT_AW-1:0]),
		.rdata (pat_rdata)
	);

	ppurp_ram #(.WIDTH(BYTE_W), .DEPTH(NAME_DEPTH)) u_name_ram (
		.clk   (clk),
		.we    (name_we),
		.waddr (name_idx),
		.wdata (wdata_q),
		.raddr (name_idx),
		.rdata (name_rdata)
	);

	ppurp_ram #(.WIDTH(BYTE_W), .DEPTH(OAM_DEPTH)) u_oam_ram (
		.clk   (clk),
		.we    (oam_we),
		.waddr (sa_q[OAM_AW-1:0]),
		.wdata (wdata_q),
		.raddr (sa_q[OAM_AW-1:0]),
		.rdata (oam_rdata)
	);

	always_ff @(posedge clk) begin
		if (dp_cmd.capture) begin
			cmd_q   <= cmd;
			addr_q  <= reg_addr;
			wdata_q <= write_data;
			vb_in_q <= vblank_set;
			sz_in_q <= sprite_zero_set;
		end
		if (dp_cmd.exec) begin
			rd_q  <= rd_n;
			err_q <= err_n;
		end
	end

	always_comb begin
		scroll_n = scroll_q;
		fine_n   = fine_q;
		va_n     = va_q;
		sa_n     = sa_q;
		toggle_n = toggle_q;
		vblank_n = vblank_q;
		sz_n     = sz_q;
		ctrl_n   = ctrl_q;
		mask_n   = mask_q;
		rd_n     = 8'h00;
		err_n    = 1'b0;
		pat_we   = 1'b0;
		name_we  = 1'b0;
		oam_we   = 1'b0;
		if (dp_cmd.exec) begin
			case (cmd_q)
				CMD_WRITE: begin
					unique case (addr_q)
						REG_CTRL: begin
							scroll_n = {4'b0010, wdata_q[1:0], 10'b0};
							ctrl_n   = wdata_q[7:2];
						end
						REG_MASK: begin
							mask_n = wdata_q[4:0];
						end
						REG_OAM_ADDR: begin
							sa_n = {8'h00, wdata_q};
						end
						REG_OAM_DATA: begin
							oam_we = 1'b1;
						end
						REG_SCROLL: begin
							if (toggle_q) begin
								scroll_n = {scroll_q[15:5], wdata_q[7:3]};
								fine_n   = wdata_q[2:0];
							end else begin
								scroll_n = {scroll_q[15], wdata_q[2:0], scroll_q[11:10],
									wdata_q[7:3], scroll_q[4:0]};
							end
							toggle_n = !toggle_q;
						end
						REG_ADDR: begin
							if (toggle_q) begin
								va_n = {2'b00, wdata_q[5:0], va_q[7:0]};
							end else begin
								va_n = {va_q[15:8], wdata_q};
								sa_n = va_n;
							end
							toggle_n = !toggle_q;
						end
						REG_DATA: begin
							// Palette writes land nowhere visible: palette reads return zero.
							pat_we  = is_pat;
							name_we = is_name;
							va_n    = va_q + 16'd1;
						end
						REG_OAM_DMA: begin
							sa_n = {wdata_q, 8'h00};
						end
						default: begin
							err_n = 1'b0;
						end
					endcase
				end
				CMD_READ: begin
					unique case (addr_q)
						REG_STATUS: begin
							rd_n     = {vblank_q, sz_q, 6'b0};
							vblank_n = 1'b0;
							toggle_n = 1'b1;
						end
						REG_OAM_DATA: begin
							rd_n = oam_rdata;
						end
						REG_DATA: begin
							if (is_pat) begin
								rd_n = pat_rdata;
							end else if (is_name) begin
								rd_n = name_rdata;
							end
							va_n = va_q + 16'd1;
						end
						default: begin
							err_n = 1'b1;
						end
					endcase
				end
				CMD_EVENT: begin
					vblank_n = vb_in_q;
					sz_n     = sz_in_q;
				end
				default: begin
					err_n = 1'b0;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scroll_q <= '0;
			fine_q   <= '0;
			va_q     <= '0;
			sa_q     <= SPRITE_ADDR_RST;
			toggle_q <= 1'b1;
			vblank_q <= 1'b0;
			sz_q     <= 1'b0;
			ctrl_q   <= CTRL_RST;
			mask_q   <= MASK_RST;
		end else begin
			scroll_q <= scroll_n;
			fine_q   <= fine_n;
			va_q     <= va_n;
			sa_q     <= sa_n;
			toggle_q <= toggle_n;
			vblank_q <= vblank_n;
			sz_q     <= sz_n;
			ctrl_q   <= ctrl_n;
			mask_q   <= mask_n;
		end
	end

	assign read_data             = rd_q;
	assign access_error          = err_q;
	assign nametable_scroll_addr = scroll_q;
	assign fine_x                = fine_q;
	assign vram_addr_out         = va_q;
	assign oam_addr_out          = sa_q;
	assign nmi_enable            = ctrl_q[5];
	assign tall_sprites          = ctrl_q[3];
	assign sprite_table_sel      = ctrl_q[1];
	assign background_table_sel  = ctrl_q[2];
	assign background_on         = mask_q[3];
	assign sprites_on            = mask_q[4];

endmodule

### src/ppu_cpu_register_port.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppu_cpu_register_port: CPU-facing register port of a picture processor
// Control, mask, status, scroll, address, sprite attribute and data port
// registers, with pattern, nametable and sprite attribute memories behind
// the data and OAM data ports.
// ----------------------------------------------------------------------------
//
//  Channel   | Handshake        | Payload
//  ----------+------------------+-----------------------------------------------
//  request   | start / busy     | cmd, reg_addr, write_data, vblank_set,
//            |                  | sprite_zero_set
//  result    | done (strobe)    | read_data, access_error, scroll, address and
//            |                  | flag outputs
//
// A transaction is accepted at a rising edge with start high and busy low.
// The next cycle is the execute cycle (busy high): the registered reads of the
// pattern, nametable and sprite attribute memories return their data and all
// register updates and memory writes take effect at its end. In the cycle
// after that, done is high for exactly one cycle and the result ports show
// the transaction's result. A new transaction may be accepted in that same
// strobe cycle. The receiver cannot stall; results are never held. Reset
// clears scroll, fine X, video address and the vblank and sprite zero flags,
// sets the write toggle and loads sprite address, control and mask reset
// values; memory contents are undefined until written.
module ppu_cpu_register_port
	import ppurp_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  cmd,
	input  logic [15:0] reg_addr,
	input  logic [7:0]  write_data,
	input  logic        vblank_set,
	input  logic        sprite_zero_set,
	output logic        done,
	output logic [7:0]  read_data,
	output logic        access_error,
	output logic [15:0] nametable_scroll_addr,
	output logic [2:0]  fine_x,
	output logic [15:0] vram_addr_out,
	output logic [15:0] oam_addr_out,
	output logic        nmi_enable,
	output logic        tall_sprites,
	output logic        sprite_table_sel,
	output logic        background_table_sel,
	output logic        background_on,
	output logic        sprites_on
);

	dp_cmd_t dp_cmd;

	// The controller owns the handshake; the datapath only sees its commands.
	ppurp_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.done   (done),
		.dp_cmd (dp_cmd)
	);

	ppurp_dp u_dp (
		.clk                   (clk),
		.arst_n                (arst_n),
		.dp_cmd                (dp_cmd),
		.cmd                   (cmd),
		.reg_addr              (reg_addr),
		.write_data            (write_data),
		.vblank_set            (vblank_set),
		.sprite_zero_set       (sprite_zero_set),
		.read_data             (read_data),
		.access_error          (access_error),
		.nametable_scroll_addr (nametable_scroll_addr),
		.fine_x                (fine_x),
		.vram_addr_out         (vram_addr_out),
		.oam_addr_out          (oam_addr_out),
		.nmi_enable            (nmi_enable),
		.tall_sprites          (tall_sprites),
		.sprite_table_sel      (sprite_table_sel),
		.background_table_sel  (background_table_sel),
		.background_on         (background_on),
		.sprites_on            (sprites_on)
	);

	// An accepted transaction moves into its execute cycle, without a strobe.
	a_accept_exec: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (busy && !done))
		else $error("accepted transaction did not enter execute");

	// Every execute cycle is followed by exactly one result strobe.
	a_exec_done: assert property (@(posedge clk) disable iff (!arst_n)
		busy |=> (done && !busy))
		else $error("execute cycle not followed by result strobe");

	// A strobe is never issued without a transaction before it.
	a_done_prior: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result strobe without a transaction");

	// A rejected read returns no data.
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && access_error) |-> (read_data == 8'h00))
		else $error("access error with nonzero read data");

endmodule
